/* sv/pgvu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgvu_pkg
// shared types and constants of the packed grid value unpacker
// ---------------------------------------------------------------------------
package pgvu_pkg;

   localparam int ACC_BITS     = 40;
   localparam int RESULT_LIMIT = 64;
   localparam int CNT_W        = 24;
   localparam int VAL_W        = 48;

   localparam logic [1:0] CMD_BITMAP = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_DRAIN  = 2'd2;
   localparam logic [1:0] CMD_START  = 2'd3;

   localparam logic [2:0] CSR_CODE_WIDTH = 3'd0;
   localparam logic [2:0] CSR_BITMAP_EN  = 3'd1;
   localparam logic [2:0] CSR_SKIP_FIRST = 3'd2;
   localparam logic [2:0] CSR_POINT_TOT  = 3'd3;
   localparam logic [2:0] CSR_REF_VALUE  = 3'd4;
   localparam logic [2:0] CSR_SCALE      = 3'd5;

   // controller -> datapath
   typedef struct packed {
      logic apply;    // apply the accepted word's command
      logic step;     // evaluate one grid point
      logic skip_go;  // settle a pending first-code skip when the run stalls
      logic refuse;   // load a refusal word
      logic mul_go;   // start the value multiply
      logic fin;      // finish value into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic open;      // record not finished
      logic overflow;  // accepted byte would overflow its queue
      logic can_emit;  // next point is ready
      logic need_mul;  // next point needs the multiply
   } status_type;

endpackage
`default_nettype wire

/* sv/pgvu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgvu_ctrl
// sequencer: takes a word, applies or refuses it, then releases points one at a time
// ---------------------------------------------------------------------------
module pgvu_ctrl
   import pgvu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     out_last,
   input  wire pgvu_pkg::status_type stat,
   output pgvu_pkg::cmd_type        cmd
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_EVAL  = 6'b000100,
      S_MUL   = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] count_ff, count_in;
   logic       last_ff, last_in;
   logic       more;

   // another point follows in this run
   assign more = stat.open && stat.can_emit && (count_ff < 7'(RESULT_LIMIT));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
               count_in = '0;
            end
         end
         S_CHECK: begin
            if (stat.overflow) begin
               cmd.refuse = 1'b1;
               last_in    = 1'b1;
               state_in   = S_OUT;
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            if (more) begin
               cmd.step = 1'b1;
               count_in = count_ff + 7'd1;
               state_in = stat.need_mul ? S_MUL : S_FIN;
            end else begin
               // a stalled point still takes the pending skip
               cmd.skip_go = stat.open && (count_ff < 7'(RESULT_LIMIT));
               state_in    = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            // last when the next point cannot follow
            last_in  = !(stat.open && stat.can_emit && (count_ff < 7'(RESULT_LIMIT)));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = last_ff ? S_IDLE : S_EVAL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign out_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(RESULT_LIMIT)) else $error("run too long");
endmodule
`default_nettype wire

/* sv/pgvu_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgvu_dp
// datapath: bit accumulator, bitmap queue, point counter and value arithmetic
// ---------------------------------------------------------------------------
module pgvu_dp
   import pgvu_pkg::*;
#(
   parameter int BITMAP_QUEUE_BITS = 64,
   parameter int MAX_CODE_BITS     = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              word_take,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [7:0]        req_byte,
   input  wire logic              csr_wen,
   input  wire logic [2:0]        csr_index,
   input  wire logic [47:0]       csr_wdata,
   input  wire pgvu_pkg::cmd_type  cmd,
   output pgvu_pkg::status_type   stat,
   output logic                   o_kind,
   output logic [47:0]            o_value,
   output logic                   o_missing,
   output logic [31:0]            o_code,
   output logic [23:0]            o_index,
   output logic                   o_done
);
   localparam int QW = $clog2(BITMAP_QUEUE_BITS + 1);
   localparam int QI = $clog2(BITMAP_QUEUE_BITS);
   localparam int WW = $clog2(MAX_CODE_BITS + 1);

   logic [5:0]  cw_ff;
   logic        bm_en_ff, skip_cfg_ff;
   logic [23:0] total_ff;
   logic [47:0] ref_ff, scale_ff;

   logic [ACC_BITS-1:0]          acc_ff, acc_in;
   logic [5:0]                   nacc_ff, nacc_in;
   logic [BITMAP_QUEUE_BITS-1:0] bq_ff, bq_in;
   logic [QW-1:0]                nbq_ff, nbq_in;
   logic [23:0]                  pc_ff, pc_in;
   logic                         skip_ff, skip_in;
   logic [1:0]                   wcmd_ff;
   logic [7:0]                   wbyte_ff;

   logic [WW-1:0] w;
   logic [5:0]    w6;
   logic          skip_eff;
   logic [5:0]    nacc_eff;
   logic [QI-1:0] bq_sel;
   logic          present;
   logic [ACC_BITS-1:0] shifted;
   logic [31:0]   code;

   logic [31:0] code_ff;
   logic        miss_ff, kind_ff, done_ff, mulsel_ff;
   logic [23:0] idx_ff;
   logic [55:0] hi_ff;
   logic [55:0] lo_ff;
   logic [47:0] val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= '0; bm_en_ff <= 1'b0; skip_cfg_ff <= 1'b0;
         total_ff <= '0; ref_ff <= '0; scale_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_CODE_WIDTH: cw_ff       <= csr_wdata[5:0];
            CSR_BITMAP_EN:  bm_en_ff    <= csr_wdata[0];
            CSR_SKIP_FIRST: skip_cfg_ff <= csr_wdata[0];
            CSR_POINT_TOT:  total_ff    <= csr_wdata[23:0];
            CSR_REF_VALUE:  ref_ff      <= csr_wdata;
            CSR_SCALE:      scale_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w  = (cw_ff > 6'(MAX_CODE_BITS)) ? WW'(MAX_CODE_BITS) : WW'(cw_ff);
   assign w6 = 6'(w);

   // skip first code resolves before the point looks at the accumulator
   always_comb begin
      skip_eff = skip_ff;
      nacc_eff = nacc_ff;
      if (skip_ff) begin
         if (w6 == 6'd0) skip_eff = 1'b0;
         else if (nacc_ff >= w6) begin
            skip_eff = 1'b0;
            nacc_eff = nacc_ff - w6;
         end
      end
   end

   assign bq_sel  = QI'(nbq_ff - QW'(1));
   assign present = bm_en_ff ? bq_ff[bq_sel] : 1'b1;
   assign shifted = acc_ff >> (nacc_eff - w6);
   always_comb begin
      code = '0;
      for (int i = 0; i < 32; i++)
         if (i < int'(w6)) code[i] = shifted[i];
   end

   assign stat.open     = pc_ff < total_ff;
   assign stat.overflow = (wcmd_ff == CMD_BITMAP && stat.open && bm_en_ff &&
                           (32'(nbq_ff) + 32'd8 > 32'(BITMAP_QUEUE_BITS))) ||
                          (wcmd_ff == CMD_DATA && stat.open &&
                           (32'(nacc_ff) + 32'd8 > 32'(ACC_BITS)));
   assign stat.can_emit = !(bm_en_ff && nbq_ff == '0) &&
                          !(present && w6 != 6'd0 && (skip_eff || nacc_eff < w6));
   assign stat.need_mul = present && w6 != 6'd0;

   always_comb begin
      acc_in = acc_ff; nacc_in = nacc_ff; bq_in = bq_ff; nbq_in = nbq_ff;
      pc_in = pc_ff; skip_in = skip_ff;
      if (cmd.apply) begin
         case (wcmd_ff)
            CMD_START: begin
               acc_in = '0; nacc_in = '0; bq_in = '0; nbq_in = '0;
               pc_in = '0; skip_in = skip_cfg_ff;
            end
            CMD_BITMAP: if (stat.open && bm_en_ff) begin
               bq_in  = {bq_ff[BITMAP_QUEUE_BITS-9:0], wbyte_ff};
               nbq_in = nbq_ff + QW'(8);
            end
            CMD_DATA: if (stat.open) begin
               acc_in  = {acc_ff[ACC_BITS-9:0], wbyte_ff};
               nacc_in = nacc_ff + 6'd8;
            end
            default: ;
         endcase
      end else if (cmd.step) begin
         skip_in = skip_eff;
         nacc_in = (present && w6 != 6'd0) ? nacc_eff - w6 : nacc_eff;
         if (bm_en_ff) nbq_in = nbq_ff - QW'(1);
         pc_in = pc_ff + 24'd1;
      end else if (cmd.skip_go) begin
         skip_in = skip_eff;
         nacc_in = nacc_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; nacc_ff <= '0; bq_ff <= '0; nbq_ff <= '0;
         pc_ff <= '0; skip_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in; nacc_ff <= nacc_in; bq_ff <= bq_in; nbq_ff <= nbq_in;
         pc_ff <= pc_in; skip_ff <= skip_in;
      end
   end

   // two 32x24 partial products, then round, add and saturate
   logic signed [49:0] sum;
   always_comb begin
      sum = 50'(signed'(ref_ff)) +
            signed'(50'({hi_ff[47:0], 8'd0} + 56'((lo_ff + 56'h8000) >> 16)));
   end

   always_ff @(posedge clock) begin
      if (word_take) begin
         wcmd_ff  <= req_cmd;
         wbyte_ff <= req_byte;
      end
      if (cmd.step) begin
         code_ff   <= (present && w6 != 6'd0) ? code : 32'd0;
         miss_ff   <= !present;
         mulsel_ff <= present && w6 != 6'd0;
         idx_ff    <= pc_ff;
         done_ff   <= (pc_ff + 24'd1) == total_ff;
         kind_ff   <= 1'b0;
         val_ff    <= present ? ref_ff : 48'd0;
      end
      if (cmd.mul_go) begin
         hi_ff <= 56'(code_ff) * 56'(scale_ff[47:24]);
         lo_ff <= 56'(code_ff) * 56'(scale_ff[23:0]);
      end
      if (cmd.fin && mulsel_ff) begin
         if (hi_ff >= 56'(1) << 40) val_ff <= 48'h7FFF_FFFF_FFFF;
         else if (sum > 50'sh7FFF_FFFF_FFFF) val_ff <= 48'h7FFF_FFFF_FFFF;
         else if (sum < -50'sh8000_0000_0000) val_ff <= 48'h8000_0000_0000;
         else val_ff <= sum[47:0];
      end
      if (cmd.refuse) begin
         kind_ff <= 1'b1; val_ff <= '0; miss_ff <= 1'b0; code_ff <= '0;
         idx_ff <= '0; done_ff <= 1'b0;
      end
   end

   assign o_kind = kind_ff; assign o_value = val_ff; assign o_missing = miss_ff;
   assign o_code = code_ff; assign o_index = idx_ff; assign o_done = done_ff;

   a_acc: assert property (@(posedge clock) disable iff (reset)
      nacc_ff <= 6'(ACC_BITS)) else $error("accumulator overfilled");
   a_bq: assert property (@(posedge clock) disable iff (reset)
      32'(nbq_ff) <= 32'(BITMAP_QUEUE_BITS)) else $error("bitmap queue overfilled");
   a_pc: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> stat.open) else $error("point beyond record");
endmodule
`default_nettype wire

/* sv/packed_grid_value_unpacker_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// packed_grid_value_unpacker_top
// decodes simply packed grid values from bitmap and data bytes
// ---------------------------------------------------------------------------
// req_ carries one command word (bitmap byte, data byte, drain, start record).
// each word releases zero to 64 grid point words on rsp_, the last of a run
// flagged by rsp_tlast, or a single refusal word when a queue would overflow.
// a word is taken, then checked and applied in the following cycle; each point
// then passes through eval, finish and the output register, with a multiply
// step between eval and finish when a code goes through the multiply.
// a word with no points returns the sequencer from eval to idle.
// the next req_ word is taken only after the run ends.
// a stalled receiver holds the output word; the sequencer waits with it.
// reset clears control, csr and record state; csr_ writes go anytime idle.
// ---------------------------------------------------------------------------
module packed_grid_value_unpacker_top
   import pgvu_pkg::*;
#(
   parameter int BITMAP_QUEUE_BITS = 64,
   parameter int MAX_CODE_BITS     = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // cmd[1:0], byte_value[9:2], zero fill
   input  wire logic         rsp_tready,
   output logic              rsp_tvalid,
   output logic [111:0]      rsp_tdata,   // point_value[47:0], missing[48],
                                          // raw_code[80:49], point_index[104:81]
                                          // record_done[105], zero fill
   output logic              rsp_tuser,   // kind
   output logic              rsp_tlast,   // run_last
   input  wire logic         csr_wen,
   input  wire logic [2:0]   csr_index,
   input  wire logic [47:0]  csr_wdata
);
   cmd_type    cmd;
   status_type stat;
   logic       kind, missing, done;
   logic [47:0] value;
   logic [31:0] code;
   logic [23:0] index;

   pgvu_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tready, .rsp_tvalid,
      .out_last(rsp_tlast), .stat, .cmd
   );

   pgvu_dp #(.BITMAP_QUEUE_BITS(BITMAP_QUEUE_BITS), .MAX_CODE_BITS(MAX_CODE_BITS))
   u_dp (
      .clock, .reset, .word_take(req_tvalid && req_tready),
      .req_cmd(req_tdata[1:0]), .req_byte(req_tdata[9:2]),
      .csr_wen, .csr_index, .csr_wdata, .cmd, .stat,
      .o_kind(kind), .o_value(value), .o_missing(missing), .o_code(code),
      .o_index(index), .o_done(done)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {6'd0, done, index, code, missing, value};
endmodule
`default_nettype wire

/* verif/packed_grid_value_unpacker_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packed_grid_value_unpacker_top_tb
// self-checking bench: bitmap, data, drain and start words are driven on req_,
// an in-bench decoder predicts each grid point word, rsp_ words are compared
// field by field in order while both sides idle at random
// ---------------------------------------------------------------------------
module packed_grid_value_unpacker_top_tb;
   import pgvu_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [47:0] value;
      logic        missing;
      logic [31:0] code;
      logic [23:0] index;
      logic        done;
      logic        last;
   } point_word_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         rsp_tready = 0;
   logic         rsp_tvalid;
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wen = 0;
   logic [2:0]   csr_index = '0;
   logic [47:0]  csr_wdata = '0;

   packed_grid_value_unpacker_top DUT (.*);

   always #10 clock = ~clock;

   // predictor copy of registers and record state
   logic [5:0]  cfg_width;
   logic        cfg_bitmap, cfg_skip;
   logic [23:0] cfg_total;
   logic [47:0] cfg_ref, cfg_scale;
   logic [39:0] acc;
   int unsigned acc_bits;
   logic [63:0] bmq;
   int unsigned bmq_bits;
   logic [23:0] pt_count;
   logic        skip_pend;

   point_word_type expected_points[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0, words_sent = 0, points_seen = 0, refusals_seen = 0;
   longint cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("timeout");
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [47:0] point_value(logic [31:0] c);
      logic signed [49:0] sum;
      logic [55:0] hi;
      logic [55:0] lo;
      hi = 56'(c) * 56'(cfg_scale[47:24]);
      lo = 56'(c) * 56'(cfg_scale[23:0]) + 56'h8000;
      if (hi >= (56'd1 << 40)) return 48'h7FFF_FFFF_FFFF;
      sum = $signed({{2{cfg_ref[47]}}, cfg_ref}) + $signed({2'b0, hi[39:0], 8'd0}) +
            $signed({10'd0, lo[55:16]});
      if (sum > 50'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
      if (sum < -50'sh8000_0000_0000) return 48'h8000_0000_0000;
      return sum[47:0];
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CODE_WIDTH: cfg_width = val[5:0];
         CSR_BITMAP_EN:  cfg_bitmap = val[0];
         CSR_SKIP_FIRST: cfg_skip = val[0];
         CSR_POINT_TOT:  cfg_total = val[23:0];
         CSR_REF_VALUE:  cfg_ref = val;
         default:        cfg_scale = val;
      endcase
   endtask

   task automatic predict_word(logic [1:0] cmd, logic [7:0] b);
      point_word_type w;
      int n, wd;
      logic present;
      logic [31:0] c;
      logic open;
      n = 0;
      open = pt_count < cfg_total;
      wd = (cfg_width > 32) ? 32 : cfg_width;
      if (cmd == CMD_START) begin
         acc = 0; acc_bits = 0; bmq = 0; bmq_bits = 0; pt_count = 0; skip_pend = cfg_skip;
      end else if ((cmd == CMD_BITMAP && open && cfg_bitmap && bmq_bits + 8 > 64) ||
                   (cmd == CMD_DATA && open && acc_bits + 8 > 40)) begin
         w = '0; w.kind = 1; w.last = 1;
         expected_points.push_back(w);
         return;
      end else if (cmd == CMD_BITMAP && open && cfg_bitmap) begin
         bmq = {bmq[55:0], b}; bmq_bits += 8;
      end else if (cmd == CMD_DATA && open) begin
         acc = {acc[31:0], b}; acc_bits += 8;
      end
      while (n < RESULT_LIMIT && pt_count < cfg_total) begin
         present = 1; c = 0;
         if (skip_pend) begin
            if (wd == 0) skip_pend = 0;
            else if (acc_bits >= wd) begin acc_bits -= wd; skip_pend = 0; end
         end
         if (cfg_bitmap) begin
            if (bmq_bits == 0) break;
            present = bmq[bmq_bits-1];
         end
         if (present && wd > 0) begin
            if (skip_pend || acc_bits < wd) break;
            c = 32'((acc >> (acc_bits - wd)) & ((41'd1 << wd) - 1));
            acc_bits -= wd;
         end
         if (cfg_bitmap) bmq_bits--;
         w = '0;
         w.value = !present ? 48'd0 : (wd > 0 ? point_value(c) : cfg_ref);
         w.missing = !present; w.code = c; w.index = pt_count;
         w.done = (pt_count + 1 == cfg_total);
         expected_points.push_back(w);
         pt_count++; n++;
      end
      if (n > 0) expected_points[$].last = 1;
   endtask

   task automatic send_word(logic [1:0] cmd, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= {6'd0, b, cmd};
      predict_word(cmd, b);
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         point_word_type got, exp;
         got = {rsp_tuser, rsp_tdata[47:0], rsp_tdata[48], rsp_tdata[80:49],
                rsp_tdata[104:81], rsp_tdata[105], rsp_tlast};
         if (got.kind) refusals_seen++; else points_seen++;
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", got);
         end else begin
            exp = expected_points.pop_front();
            if (got !== exp) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch kind %0b/%0b value %h/%h miss %0b/%0b",
                            " code %h/%h idx %0d/%0d done %0b/%0b last %0b/%0b"},
                     exp.kind, got.kind, exp.value, got.value, exp.missing, got.missing,
                     exp.code, got.code, exp.index, got.index, exp.done, got.done,
                     exp.last, got.last);
            end
         end
      end
   end

   task automatic settle();
      req_tvalid <= 0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(int wd, bit bm, bit sk, int total, logic [47:0] rv, logic [47:0] sc);
      settle();
      write_reg(CSR_CODE_WIDTH, wd); write_reg(CSR_BITMAP_EN, bm);
      write_reg(CSR_SKIP_FIRST, sk); write_reg(CSR_POINT_TOT, total);
      write_reg(CSR_REF_VALUE, rv); write_reg(CSR_SCALE, sc);
      csr_wen <= 0;
      send_word(CMD_START, $urandom);
   endtask

   task automatic test_directed();
      // wide codes, full scale saturation, skip of first code
      setup(32, 0, 1, 3, 48'h7FFF_0000_0000, 48'hFFFF_FFFF_FFFF);
      repeat (8) send_word(CMD_DATA, 8'hFF);
      send_word(CMD_DATA, 8'h00); send_word(CMD_DATA, 8'h00);
      repeat (6) send_word(CMD_DATA, 8'hA5); // completes the last two points
      // bitmap, missing points, bitmap queue overflow, most negative reference value
      setup(1, 1, 0, 70, 48'h8000_0000_0000, 48'h0);
      repeat (9) send_word(CMD_BITMAP, 8'h5A);
      send_word(CMD_DATA, 8'hFF); send_word(CMD_DATA, 8'h00);
      // constant field, zero points, drain of backlog beyond 64 points
      setup(0, 0, 1, 0, 48'h1234_5678_9ABC, 48'd1);
      send_word(CMD_DATA, 8'h11); send_word(CMD_DRAIN, 0);
      setup(0, 0, 0, 150, 48'h0000_0001_0000, 48'd1);
      send_word(CMD_DRAIN, 0); send_word(CMD_DRAIN, 0);
      setup(63, 0, 0, 2, 48'h0, 48'h0001_0000_0000);
      repeat (4) send_word(CMD_DATA, $urandom);
   endtask

   task automatic test_random(int words);
      int k, r;
      k = 0;
      while (k < words) begin
         setup($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(12),
               $urandom_range(1), $urandom_range(3) == 0, $urandom_range(1, 24),
               {$urandom, $urandom}, $urandom_range(3) == 0 ? {$urandom, $urandom} :
               48'($urandom_range(1 << 20)));
         repeat ($urandom_range(6, 20)) begin
            r = $urandom_range(99);
            if (r < 45) send_word(CMD_DATA, $urandom);
            else if (r < 85) send_word(CMD_BITMAP, $urandom);
            else if (r < 95) send_word(CMD_DRAIN, $urandom);
            else send_word(CMD_START, $urandom);
            k++;
         end
      end
   endtask

   initial begin
      cfg_width = 0; cfg_bitmap = 0; cfg_skip = 0; cfg_total = 0; cfg_ref = 0;
      cfg_scale = 0; acc = 0; acc_bits = 0; bmq = 0; bmq_bits = 0; pt_count = 0;
      skip_pend = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 36; recv_stall_pct = 71;
      test_directed();
      test_random(90);
      send_idle_pct = 71; recv_stall_pct = 36;
      test_random(85);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(85);
      settle();
      $display("sent %0d words, checked %0d points and %0d refusals",
               words_sent, points_seen, refusals_seen);
      if (errors == 0 && expected_points.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
